@@ hw/rtl/bm25sa_pkg.sv @@
// Shared types, constants and a helper function for the BM25 score accumulator.
package bm25sa_pkg;

  // Accumulator store geometry.
  localparam int MAX_DOCS = 1024;
  localparam int DOC_AW   = $clog2(MAX_DOCS);

  // Queue between the front and back parts.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  // Most transactions that can be inside the block at once:
  // queue entries, the item in the back part and the output register.
  localparam int PEND_MAX = FIFO_DEPTH + 2;

  // ln 2 in Q0.32.
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // Register reset values.
  localparam logic [9:0] K_ONE_RST    = 10'd307;
  localparam logic [8:0] B_WEIGHT_RST = 9'd192;
  localparam logic [8:0] B_ONE        = 9'd256;

  // Configuration register indexes (byte address / 4).
  typedef enum logic [1:0] {
    REG_DOC_COUNT   = 2'd0,
    REG_AVG_DOC_LEN = 2'd1,
    REG_K_ONE       = 2'd2,
    REG_B_WEIGHT    = 2'd3
  } reg_idx_t;

  // Input command codes.
  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [20:0] doc_count;
    logic [27:0] avg_doc_len;
    logic [9:0]  k_one;
    logic [8:0]  b_weight;
  } cfg_t;

  // Classified item as it travels through the queue.
  typedef struct packed {
    cmd_t        cmd;
    logic        idx_ok;
    logic        skip;
    logic [9:0]  doc_index;
    logic [15:0] tf;
    logic [19:0] len;
    logic [20:0] df;
  } work_t;

  // Request and response between the back part and the score unit.
  typedef struct packed {
    logic        start;
    logic        skip;
    logic [15:0] tf;
    logic [19:0] len;
    logic [20:0] df;
  } score_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] score;
  } score_rsp_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_CALC,
    BK_READ,
    BK_UPD
  } back_state_t;

  typedef enum logic [3:0] {
    SC_IDLE,
    SC_LOG,
    SC_IDF,
    SC_DIV1,
    SC_NORM,
    SC_DEN,
    SC_DIV2,
    SC_MUL,
    SC_DONE
  } score_state_t;

  // Index of the highest set bit (0 when no bit is set).
  function automatic logic [4:0] top_bit(input logic [22:0] x);
    logic [4:0] r;
    r = '0;
    for (int i = 0; i < 23; i++) begin
      if (x[i]) r = 5'(i);
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/bm25sa_if.sv @@
// Valid/ready channel interfaces for postings in and scores out.
interface bm25sa_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [9:0]  doc_index;
  logic [15:0] term_count;
  logic [19:0] doc_length;
  logic [20:0] doc_freq;

  modport source(output valid, command, doc_index, term_count, doc_length, doc_freq,
                 input ready);
  modport sink(input valid, command, doc_index, term_count, doc_length, doc_freq,
               output ready);
endinterface

interface bm25sa_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  doc_out;
  logic [31:0] term_score;
  logic [31:0] total_score;

  modport source(output valid, doc_out, term_score, total_score, input ready);
  modport sink(input valid, doc_out, term_score, total_score, output ready);
endinterface

@@ hw/rtl/bm25sa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bm25sa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) rdata <= mem_r[raddr];
  end

endmodule

@@ hw/rtl/bm25sa_front.sv @@
// Front part: accepts postings, clamps df and classifies each transaction.
module bm25sa_front import bm25sa_pkg::*; (
  bm25sa_in_if.sink in_chan,
  input  cfg_t      cfg,
  input  logic      accept_en,
  input  logic      fifo_full,
  output logic      push,
  output work_t     push_data
);

  logic [20:0] df_c;

  // Handshake: take a transaction whenever accept_en is high and the queue has room.
  assign in_chan.ready = accept_en && !fifo_full;
  assign push          = in_chan.valid && in_chan.ready;

  // Clamp df to N and flag postings whose score is zero by definition.
  always_comb begin
    df_c = (in_chan.doc_freq > cfg.doc_count) ? cfg.doc_count : in_chan.doc_freq;
    push_data.cmd       = cmd_t'(in_chan.command);
    push_data.idx_ok    = 32'(in_chan.doc_index) < MAX_DOCS;
    push_data.skip      = (df_c == '0) || (cfg.avg_doc_len == '0);
    push_data.doc_index = in_chan.doc_index;
    push_data.tf        = in_chan.term_count;
    push_data.len       = in_chan.doc_length;
    push_data.df        = df_c;
  end

endmodule

@@ hw/rtl/bm25sa_fifo.sv @@
// Short queue of classified transactions between the front and back parts.
module bm25sa_fifo import bm25sa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  work_t push_data,
  output logic  full,
  input  logic  pop,
  output work_t pop_data,
  output logic  empty
);

  work_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;

  assign full     = cnt_r == (FIFO_AW + 1)'(FIFO_DEPTH);
  assign empty    = cnt_r == '0;
  assign pop_data = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

@@ hw/rtl/bm25sa_score.sv @@
// Score unit: sequential BM25 term score with log, divide and multiply steps; both divides share one step.
module bm25sa_score import bm25sa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  score_req_t req,
  output score_rsp_t rsp
);

  score_state_t state_r, state_nxt;
  logic [5:0]   cnt_r;
  logic [15:0]  tf_r;
  logic [19:0]  len_r;
  logic [30:0]  ma_r, mb_r;
  logic [15:0]  fa_r, fb_r;
  logic [4:0]   ea_r, eb_r;
  logic [20:0]  idf_r;
  logic [48:0]  rem_r;
  logic [48:0]  dsr_r;
  logic [43:0]  dvd_r;
  logic [45:0]  norm_r;
  logic [31:0]  score_r;

  // Log setup values.
  logic [22:0]  xa, xb;
  logic [4:0]   ea, eb;
  // Squaring step.
  logic [61:0]  sqa, sqb;
  logic [31:0]  ta, tb;
  // Logarithm difference and idf product.
  logic [20:0]  la, lb, ldiff;
  logic [52:0]  idf_prod;
  // Divider step.
  logic [49:0]  r2;
  logic         ge;
  logic [48:0]  rem_step;
  // Normalization and denominator.
  logic [8:0]   bw_s;
  logic [52:0]  bprod;
  logic [55:0]  kprod;
  logic [48:0]  den;
  logic [26:0]  num;
  logic [50:0]  dividend;
  logic [39:0]  sprod;

  always_comb begin
    xa  = 23'({cfg.doc_count, 1'b0}) + 23'd2;
    xb  = 23'({req.df, 1'b1});
    ea  = top_bit(xa);
    eb  = top_bit(xb);

    sqa = 62'(ma_r) * 62'(ma_r);
    sqb = 62'(mb_r) * 62'(mb_r);
    ta  = sqa[61:30];
    tb  = sqb[61:30];

    la       = {ea_r, fa_r};
    lb       = {eb_r, fb_r};
    ldiff    = la - lb;
    idf_prod = 53'(ldiff) * 53'(LN2_Q32);

    r2       = {rem_r, dvd_r[43]};
    ge       = r2 >= {1'b0, dsr_r};
    rem_step = ge ? 49'(r2 - {1'b0, dsr_r}) : r2[48:0];

    bw_s  = (cfg.b_weight > B_ONE) ? B_ONE : cfg.b_weight;
    bprod = 53'(bw_s) * 53'(dvd_r);
    kprod = 56'(cfg.k_one) * 56'(norm_r);
    den   = 49'({tf_r, 16'b0}) + 49'(kprod[55:8]);
    num   = 27'(tf_r) * (27'(cfg.k_one) + 27'd256);
    dividend = {num, 24'b0};
    sprod = 40'(idf_r) * 40'(dvd_r[18:0]);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SC_IDLE: if (req.start) state_nxt = req.skip ? SC_DONE : SC_LOG;
      SC_LOG:  if (cnt_r == '0) state_nxt = SC_IDF;
      SC_IDF:  state_nxt = SC_DIV1;
      SC_DIV1: if (cnt_r == '0) state_nxt = SC_NORM;
      SC_NORM: state_nxt = SC_DEN;
      SC_DEN:  state_nxt = (den == '0) ? SC_DONE : SC_DIV2;
      SC_DIV2: if (cnt_r == '0) state_nxt = SC_MUL;
      SC_MUL:  state_nxt = SC_DONE;
      SC_DONE: state_nxt = SC_IDLE;
      default: state_nxt = SC_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    rsp.done  = state_r == SC_DONE;
    rsp.score = score_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= SC_IDLE;
    else        state_r <= state_nxt;
  end

  // Datapath registers, one step of the sequence per cycle.
  always_ff @(posedge clk) begin
    case (state_r)
      SC_IDLE: begin
        if (req.start) begin
          tf_r    <= req.tf;
          len_r   <= req.len;
          ea_r    <= ea;
          eb_r    <= eb;
          ma_r    <= 31'({8'b0, xa} << (5'd30 - ea));
          mb_r    <= 31'({8'b0, xb} << (5'd30 - eb));
          fa_r    <= '0;
          fb_r    <= '0;
          cnt_r   <= 6'd15;
          score_r <= '0;
        end
      end
      SC_LOG: begin
        // One fraction bit of each logarithm per squaring.
        ma_r  <= ta[31] ? ta[31:1] : ta[30:0];
        mb_r  <= tb[31] ? tb[31:1] : tb[30:0];
        fa_r  <= {fa_r[14:0], ta[31]};
        fb_r  <= {fb_r[14:0], tb[31]};
        cnt_r <= cnt_r - 1'b1;
      end
      SC_IDF: begin
        idf_r <= (la > lb) ? idf_prod[52:32] : '0;
        rem_r <= '0;
        dsr_r <= 49'(cfg.avg_doc_len);
        dvd_r <= {len_r, 24'b0};
        cnt_r <= 6'd43;
      end
      SC_DIV1, SC_DIV2: begin
        // Restoring division, one quotient bit per cycle.
        rem_r <= rem_step;
        dvd_r <= {dvd_r[42:0], ge};
        cnt_r <= cnt_r - 1'b1;
      end
      SC_NORM: begin
        norm_r <= 46'({9'(B_ONE - bw_s), 8'b0}) + 46'(bprod[52:8]);
      end
      SC_DEN: begin
        // The quotient stays below 2^19, so the top bits preload the remainder.
        dsr_r   <= den;
        rem_r   <= 49'(dividend[50:19]);
        dvd_r   <= {dividend[18:0], 25'b0};
        cnt_r   <= 6'd18;
        score_r <= '0;
      end
      SC_MUL: begin
        score_r <= 32'(sprod[39:16]);
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hw/rtl/bm25sa_back.sv @@
// Back part: runs each transaction, updates the accumulator store, holds the result.
module bm25sa_back import bm25sa_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         fifo_empty,
  input  work_t        head,
  output logic         pop,
  output score_req_t   sreq,
  input  score_rsp_t   srsp,
  output logic         clearing,
  bm25sa_out_if.source out_chan
);

  back_state_t       state_r, state_nxt;
  logic [DOC_AW-1:0] clr_cnt_r;
  work_t             cur_r;
  logic [31:0]       term_r;
  logic              out_valid_r;
  logic [9:0]        out_doc_r;
  logic [31:0]       out_term_r;
  logic [31:0]       out_total_r;

  logic              slot_free;
  logic              load_out;
  logic              ram_we, ram_re;
  logic [DOC_AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]       ram_wdata, ram_q;
  logic [32:0]       sum;
  logic [31:0]       total;

  bm25sa_ram #(
    .WIDTH(32),
    .DEPTH(MAX_DOCS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  assign slot_free = !out_valid_r || out_chan.ready;

  // Saturating add, or the old value for a read; zero for an out-of-range document.
  always_comb begin
    sum = {1'b0, ram_q} + {1'b0, term_r};
    if (!cur_r.idx_ok) total = '0;
    else if (cur_r.cmd == CMD_READ) total = ram_q;
    else total = sum[32] ? '1 : sum[31:0];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: if (clr_cnt_r == DOC_AW'(MAX_DOCS - 1)) state_nxt = BK_IDLE;
      BK_IDLE: begin
        if (!fifo_empty) state_nxt = (head.cmd == CMD_READ) ? BK_READ : BK_CALC;
      end
      BK_CALC: if (srsp.done) state_nxt = BK_READ;
      BK_READ: state_nxt = BK_UPD;
      BK_UPD:  if (slot_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    clearing   = state_r == BK_CLEAR;
    pop        = (state_r == BK_IDLE) && !fifo_empty;
    sreq.start = pop && (head.cmd == CMD_ADD);
    sreq.skip  = head.skip;
    sreq.tf    = head.tf;
    sreq.len   = head.len;
    sreq.df    = head.df;
    ram_re     = state_r == BK_READ;
    ram_raddr  = DOC_AW'(cur_r.doc_index);
    load_out   = (state_r == BK_UPD) && slot_free;
    ram_we     = clearing || (load_out && cur_r.idx_ok);
    ram_waddr  = clearing ? clr_cnt_r : DOC_AW'(cur_r.doc_index);
    ram_wdata  = (clearing || cur_r.cmd == CMD_READ) ? '0 : total;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  // Current transaction and result payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r  <= head;
      term_r <= '0;
    end
    if (state_r == BK_CALC && srsp.done) term_r <= srsp.score;
    if (load_out) begin
      out_doc_r   <= cur_r.doc_index;
      out_term_r  <= term_r;
      out_total_r <= total;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.doc_out     = out_doc_r;
  assign out_chan.term_score  = out_term_r;
  assign out_chan.total_score = out_total_r;

endmodule

@@ hw/rtl/bm25_score_accumulator_core.sv @@
// Top level of the BM25 score accumulator: configuration registers and part wiring.
//
//   Channel  | Dir | Handshake           | Transaction
//   in_chan  | in  | valid/ready         | command, doc_index, term_count, doc_length, doc_freq
//   out_chan | out | valid/ready         | doc_out, term_score, total_score
//   APB      | in  | psel/penable/pready | write or read of one configuration register
//
// For an add transaction the score unit runs 16 log squarings, a 44-step and a 19-step
// restoring divide, and single setup and multiply steps; the back part then does the store
// read and update. A read skips the score unit, an add with zero df or zero average length
// skips the score steps, and an add with a zero denominator skips the second divide and the multiply.
// After reset a clearing pass zeroes all MAX_DOCS store entries; in_chan.ready is low meanwhile.
// A two-entry queue takes postings while the back part works or out_chan is stalled.
module bm25_score_accumulator_core import bm25sa_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  bm25sa_in_if.sink     in_chan,
  bm25sa_out_if.source  out_chan,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  cfg_t       cfg_r;
  reg_idx_t   reg_idx;
  logic       cfg_wr;
  logic       push, pop, fifo_full, fifo_empty, clearing;
  work_t      push_data, head;
  score_req_t sreq;
  score_rsp_t srsp;

  // Configuration port.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.doc_count   <= '0;
      cfg_r.avg_doc_len <= '0;
      cfg_r.k_one       <= K_ONE_RST;
      cfg_r.b_weight    <= B_WEIGHT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DOC_COUNT:   cfg_r.doc_count   <= pwdata[20:0];
        REG_AVG_DOC_LEN: cfg_r.avg_doc_len <= pwdata[27:0];
        REG_K_ONE:       cfg_r.k_one       <= pwdata[9:0];
        REG_B_WEIGHT:    cfg_r.b_weight    <= pwdata[8:0];
        default: begin
        end
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_idx)
      REG_DOC_COUNT:   prdata = 32'(cfg_r.doc_count);
      REG_AVG_DOC_LEN: prdata = 32'(cfg_r.avg_doc_len);
      REG_K_ONE:       prdata = 32'(cfg_r.k_one);
      REG_B_WEIGHT:    prdata = 32'(cfg_r.b_weight);
      default:         prdata = '0;
    endcase
  end

  bm25sa_front u_front (
    .in_chan  (in_chan),
    .cfg      (cfg_r),
    .accept_en(!clearing),
    .fifo_full(fifo_full),
    .push     (push),
    .push_data(push_data)
  );

  bm25sa_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .full     (fifo_full),
    .pop      (pop),
    .pop_data (head),
    .empty    (fifo_empty)
  );

  bm25sa_score u_score (
    .clk  (clk),
    .rst_n(rst_n),
    .cfg  (cfg_r),
    .req  (sreq),
    .rsp  (srsp)
  );

  bm25sa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fifo_empty(fifo_empty),
    .head      (head),
    .pop       (pop),
    .sreq      (sreq),
    .srsp      (srsp),
    .clearing  (clearing),
    .out_chan  (out_chan)
  );

endmodule

@@ hw/rtl/bm25sa_checker.sv @@
// Port-level checker for the BM25 score accumulator and its bind statement.
module bm25sa_checker import bm25sa_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [9:0]  out_doc,
  input logic [31:0] out_term,
  input logic [31:0] out_total
);

  logic [2:0] pend_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Transactions accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= '0;
    else if (in_acc && !out_acc) pend_r <= pend_r + 1'b1;
    else if (out_acc && !in_acc) pend_r <= pend_r - 1'b1;
  end

  // The store clearing pass keeps the input closed right after reset.
  a_clear_closed: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_ready && !out_valid)
    else $error("input open or result shown right after reset");

  // No result without an accepted transaction behind it.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result without a pending transaction");

  // The block never holds more transactions than its storage.
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'(PEND_MAX))
    else $error("more transactions pending than the block can hold");

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_doc) && $stable(out_term)
      && $stable(out_total))
    else $error("stalled result changed");

endmodule

bind bm25_score_accumulator_core bm25sa_checker u_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_chan.valid),
  .in_ready (in_chan.ready),
  .out_valid(out_chan.valid),
  .out_ready(out_chan.ready),
  .out_doc  (out_chan.doc_out),
  .out_term (out_chan.term_score),
  .out_total(out_chan.total_score)
);
